// File: rtl/jva_pkg.sv
`default_nettype none
package jva_pkg;

   localparam int WORD_WIDTH = 64;
   localparam int VALID_WIDTH = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 2;

   localparam logic [1:0] CSR_CORR_COUNT_MODE = 2'd0;
   localparam logic [1:0] CSR_RIGHT_KIND = 2'd1;
   localparam logic [1:0] CSR_LEFT_KIND = 2'd2;

   localparam logic [1:0] MODE_ONE = 2'd0;
   localparam logic [1:0] MODE_TWO = 2'd1;
   localparam logic [1:0] MODE_FOUR = 2'd2;

   localparam logic [1:0] KIND_GENERAL = 2'd0;
   localparam logic [1:0] KIND_DIAGONAL = 2'd1;
   localparam logic [1:0] KIND_SCALAR = 2'd2;

   typedef struct packed {
      logic [63:0] vis_lo;
      logic [63:0] vis_hi;
      logic [63:0] right_gain_lo;
      logic [63:0] right_gain_hi;
      logic [63:0] left_gain_lo;
      logic [63:0] left_gain_hi;
      logic [3:0]  right_valid;
      logic [3:0]  left_valid;
      logic        flag_in;
   } req_type;

   typedef struct packed {
      logic [63:0] out_vis_lo;
      logic [63:0] out_vis_hi;
      logic        flag_out;
      logic        kind_error;
   } rsp_type;

   typedef struct packed {
      logic       four;
      logic [1:0] right_kind;
      logic [1:0] left_kind;
      logic       zero;
      logic       flag;
      logic       kerr;
      logic [1:0] nc_small;
   } ctl_type;

endpackage
`default_nettype wire

// File: rtl/jones_visibility_apply_core.sv
// Pipeline: two lane stages of multiply then round/saturate; stage 1
// results are registered into T, stage 2 results into the output register.
// Throughput: one item per cycle; four lanes per stage, whole pipeline
// advances when the output is free or being taken.
// Reset: synchronous, active high; clears valids, registers to
// corr_count_mode=2 (four), right_kind=left_kind=0 (general).
`default_nettype none
module jones_visibility_apply_core #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int GAIN_FRAC_BITS = 13
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire jva_pkg::req_type                       req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output jva_pkg::rsp_type                            rsp_data,
   input  wire logic                                   csr_write,
   input  wire logic [jva_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [jva_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);
   localparam int SW = SAMPLE_WIDTH;
   localparam int GW = GAIN_FRAC_BITS + 3;

   logic [1:0] mode_ff, rk_ff, lk_ff;
   logic       adv;
   logic [2:0] v_ff;
   logic       ov_ff;
   jva_pkg::ctl_type ctl_in;
   jva_pkg::ctl_type ctl_ff [3];

   logic signed [SW-1:0] v_re [4], v_im [4];
   logic signed [GW-1:0] ga_re [4], ga_im [4], gb_re [4], gb_im [4];
   logic signed [GW-1:0] ja_re [4], ja_im [4];
   logic signed [GW-1:0] jb_re [4], jb_im [4];
   logic signed [GW-1:0] jb_ff_re [2][4], jb_ff_im [2][4];
   logic signed [SW-1:0] t_re [4], t_im [4], o_re [4], o_im [4];
   logic [SW-1:0] m_re [4], m_im [4];
   jva_pkg::rsp_type rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jva_pkg::MODE_FOUR;
         rk_ff <= jva_pkg::KIND_GENERAL;
         lk_ff <= jva_pkg::KIND_GENERAL;
      end else if (csr_write) begin
         unique case (csr_index)
            jva_pkg::CSR_CORR_COUNT_MODE: mode_ff <= csr_data;
            jva_pkg::CSR_RIGHT_KIND: rk_ff <= csr_data;
            jva_pkg::CSR_LEFT_KIND: lk_ff <= csr_data;
            default: ;
         endcase
      end
   end

   function automatic logic signed [63:0] lane(input logic [63:0] wd, input int pos,
                                               input int w);
      logic [63:0] x;
      x = '0;
      for (int b = 0; b < 64; b++)
         if (b < w && pos + b < 64) x[b] = wd[pos + b];
         else if (b >= w && pos + w - 1 < 64) x[b] = wd[pos + w - 1];
      lane = x;
   endfunction

   function automatic logic [3:0] need(input logic [1:0] k, input logic one);
      if (k == jva_pkg::KIND_GENERAL) need = 4'hF;
      else if (k == jva_pkg::KIND_DIAGONAL && !one) need = 4'h3;
      else need = 4'h1;
   endfunction

   always_comb begin
      logic [1:0] kr, kl;
      logic one;
      logic signed [63:0] t0, t1;
      kr = (rk_ff == 2'd3) ? jva_pkg::KIND_SCALAR : rk_ff;
      kl = (lk_ff == 2'd3) ? jva_pkg::KIND_SCALAR : lk_ff;
      one = mode_ff == jva_pkg::MODE_ONE;
      for (int i = 0; i < 4; i++) begin
         t0 = lane(i < 2 ? req_data.vis_lo : req_data.vis_hi, (i % 2) * 2 * SW + SW, SW);
         t1 = lane(i < 2 ? req_data.vis_lo : req_data.vis_hi, (i % 2) * 2 * SW, SW);
         v_re[i] = t0[SW-1:0];
         v_im[i] = t1[SW-1:0];
         t0 = lane(i < 2 ? req_data.right_gain_lo : req_data.right_gain_hi,
                   (i % 2) * 2 * GW + GW, GW);
         t1 = lane(i < 2 ? req_data.right_gain_lo : req_data.right_gain_hi,
                   (i % 2) * 2 * GW, GW);
         ga_re[i] = t0[GW-1:0];
         ga_im[i] = t1[GW-1:0];
         t0 = lane(i < 2 ? req_data.left_gain_lo : req_data.left_gain_hi,
                   (i % 2) * 2 * GW + GW, GW);
         t1 = lane(i < 2 ? req_data.left_gain_lo : req_data.left_gain_hi,
                   (i % 2) * 2 * GW, GW);
         gb_re[i] = t0[GW-1:0];
         gb_im[i] = t1[GW-1:0];
      end
      for (int i = 0; i < 4; i++) begin
         if (kr == jva_pkg::KIND_GENERAL) begin
            ja_re[i] = ga_re[i]; ja_im[i] = ga_im[i];
         end else if (i == 1 || i == 2) begin
            ja_re[i] = '0; ja_im[i] = '0;
         end else begin
            ja_re[i] = (i == 3 && kr == jva_pkg::KIND_DIAGONAL) ? ga_re[1] : ga_re[0];
            ja_im[i] = (i == 3 && kr == jva_pkg::KIND_DIAGONAL) ? ga_im[1] : ga_im[0];
         end
         if (kl == jva_pkg::KIND_GENERAL) begin
            jb_re[i] = gb_re[i]; jb_im[i] = gb_im[i];
         end else if (i == 1 || i == 2) begin
            jb_re[i] = '0; jb_im[i] = '0;
         end else begin
            jb_re[i] = (i == 3 && kl == jva_pkg::KIND_DIAGONAL) ? gb_re[1] : gb_re[0];
            jb_im[i] = (i == 3 && kl == jva_pkg::KIND_DIAGONAL) ? gb_im[1] : gb_im[0];
         end
      end
      ctl_in.four = mode_ff[1];
      ctl_in.right_kind = kr;
      ctl_in.left_kind = kl;
      ctl_in.nc_small = one ? 2'd1 : 2'd2;
      ctl_in.kerr = !mode_ff[1] && (kr == jva_pkg::KIND_GENERAL || kl == jva_pkg::KIND_GENERAL);
      ctl_in.flag = req_data.flag_in || (req_data.right_valid & need(kr, one)) != need(kr, one)
                    || (req_data.left_valid & need(kl, one)) != need(kl, one);
      ctl_in.zero = ctl_in.flag || ctl_in.kerr;
   end

   assign adv = !ov_ff || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         ov_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= {v_ff[1:0], req_valid};
         ov_ff <= v_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff[0] <= ctl_in;
         ctl_ff[1] <= ctl_ff[0];
         ctl_ff[2] <= ctl_ff[1];
         jb_ff_re[0] <= jb_re; jb_ff_im[0] <= jb_im;
         jb_ff_re[1] <= jb_ff_re[0]; jb_ff_im[1] <= jb_ff_im[0];
         rsp_data <= rsp_in;
      end
   end
   assign rsp_valid = ov_ff;

   // stage 1: T = J1*V (4-corr) or v_i * diag_i (1/2-corr)
   for (genvar g = 0; g < 4; g++) begin : g_s1
      localparam int R = g / 2;
      localparam int C = g % 2;
      logic signed [SW-1:0] a_re, a_im, c_re, c_im;
      logic signed [GW-1:0] b_re, b_im, d_re, d_im;
      always_comb begin
         if (mode_ff[1]) begin
            a_re = v_re[C]; a_im = v_im[C];
            b_re = ja_re[R * 2]; b_im = ja_im[R * 2];
            c_re = v_re[2 + C]; c_im = v_im[2 + C];
            d_re = ja_re[R * 2 + 1]; d_im = ja_im[R * 2 + 1];
         end else begin
            a_re = v_re[g]; a_im = v_im[g];
            b_re = (g < 2) ? ja_re[(g * 3) % 4] : '0;
            b_im = (g < 2) ? ja_im[(g * 3) % 4] : '0;
            c_re = '0; c_im = '0; d_re = '0; d_im = '0;
         end
      end
      jva_lane #(.SW(SW), .GF(GAIN_FRAC_BITS)) u_lane (
         .clock(clock), .enable(adv), .conj(1'b0),
         .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
         .c_re(c_re), .c_im(c_im), .d_re(d_re), .d_im(d_im),
         .r_re(t_re[g]), .r_im(t_im[g]));
   end

   logic signed [SW-1:0] tr_ff [4], ti_ff [4];
   always_ff @(posedge clock) begin
      if (adv) begin
         tr_ff <= t_re;
         ti_ff <= t_im;
      end
   end

   // stage 2: R = T * J2^H
   for (genvar g = 0; g < 4; g++) begin : g_s2
      localparam int R = g / 2;
      localparam int C = g % 2;
      logic signed [SW-1:0] a_re, a_im, c_re, c_im;
      logic signed [GW-1:0] b_re, b_im, d_re, d_im;
      always_comb begin
         if (ctl_ff[1].four) begin
            a_re = tr_ff[R * 2]; a_im = ti_ff[R * 2];
            b_re = jb_ff_re[1][C * 2]; b_im = jb_ff_im[1][C * 2];
            c_re = tr_ff[R * 2 + 1]; c_im = ti_ff[R * 2 + 1];
            d_re = jb_ff_re[1][C * 2 + 1]; d_im = jb_ff_im[1][C * 2 + 1];
         end else begin
            a_re = tr_ff[g]; a_im = ti_ff[g];
            b_re = (g < 2) ? jb_ff_re[1][(g * 3) % 4] : '0;
            b_im = (g < 2) ? jb_ff_im[1][(g * 3) % 4] : '0;
            c_re = '0; c_im = '0; d_re = '0; d_im = '0;
         end
      end
      jva_lane #(.SW(SW), .GF(GAIN_FRAC_BITS)) u_lane (
         .clock(clock), .enable(adv), .conj(1'b1),
         .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
         .c_re(c_re), .c_im(c_im), .d_re(d_re), .d_im(d_im),
         .r_re(o_re[g]), .r_im(o_im[g]));
      assign m_re[g] = o_re[g];
      assign m_im[g] = o_im[g];
   end

   jva_merge #(.SW(SW)) u_merge (
      .ctl(ctl_ff[2]), .r_re(m_re), .r_im(m_im), .rsp(rsp_in));
endmodule
`default_nettype wire

// File: rtl/jva_lane.sv
`default_nettype none
// One lane: rounded, saturated a*b' + c*d' (b', d' conjugated when conj).
module jva_lane #(
   parameter int SW = 16,
   parameter int GF = 13
) (
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire logic                 conj,
   input  wire logic signed [SW-1:0] a_re,
   input  wire logic signed [SW-1:0] a_im,
   input  wire logic signed [GF+2:0] b_re,
   input  wire logic signed [GF+2:0] b_im,
   input  wire logic signed [SW-1:0] c_re,
   input  wire logic signed [SW-1:0] c_im,
   input  wire logic signed [GF+2:0] d_re,
   input  wire logic signed [GF+2:0] d_im,
   output logic signed [SW-1:0]      r_re,
   output logic signed [SW-1:0]      r_im
);
   localparam int GW = GF + 3;
   localparam int PW = SW + GW;
   localparam int AW = PW + 3;

   logic signed [PW-1:0] p_ff [8];
   logic signed [PW-1:0] p_in [8];
   logic                 conj_ff;
   logic signed [AW-1:0] sum_re;
   logic signed [AW-1:0] sum_im;

   always_comb begin
      p_in[0] = PW'(a_re) * PW'(b_re);
      p_in[1] = PW'(a_im) * PW'(b_im);
      p_in[2] = PW'(a_re) * PW'(b_im);
      p_in[3] = PW'(a_im) * PW'(b_re);
      p_in[4] = PW'(c_re) * PW'(d_re);
      p_in[5] = PW'(c_im) * PW'(d_im);
      p_in[6] = PW'(c_re) * PW'(d_im);
      p_in[7] = PW'(c_im) * PW'(d_re);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff <= p_in;
         conj_ff <= conj;
      end
   end

   function automatic logic signed [SW-1:0] rnd_sat(input logic signed [AW-1:0] s);
      logic signed [AW-1:0] q;
      logic signed [AW-1:0] mx;
      logic signed [AW-1:0] mn;
      q = (s + (AW'(1) <<< (GF - 1))) >>> GF;
      mx = (AW'(1) <<< (SW - 1)) - AW'(1);
      mn = -mx - AW'(1);
      if (q > mx) rnd_sat = mx[SW-1:0];
      else if (q < mn) rnd_sat = mn[SW-1:0];
      else rnd_sat = q[SW-1:0];
   endfunction

   always_comb begin
      if (conj_ff) begin
         sum_re = AW'(p_ff[0]) + AW'(p_ff[1]) + AW'(p_ff[4]) + AW'(p_ff[5]);
         sum_im = AW'(p_ff[3]) - AW'(p_ff[2]) + AW'(p_ff[7]) - AW'(p_ff[6]);
      end else begin
         sum_re = AW'(p_ff[0]) - AW'(p_ff[1]) + AW'(p_ff[4]) - AW'(p_ff[5]);
         sum_im = AW'(p_ff[2]) + AW'(p_ff[3]) + AW'(p_ff[6]) + AW'(p_ff[7]);
      end
   end

   assign r_re = rnd_sat(sum_re);
   assign r_im = rnd_sat(sum_im);
endmodule
`default_nettype wire

// File: rtl/jva_merge.sv
`default_nettype none
// Packs lane results into the output words, clears lanes unused in the mode, and applies flag/error zeroing.
module jva_merge #(
   parameter int SW = 16
) (
   input  wire jva_pkg::ctl_type   ctl,
   input  wire logic [SW-1:0]      r_re [4],
   input  wire logic [SW-1:0]      r_im [4],
   output jva_pkg::rsp_type        rsp
);
   logic [63:0] w [2];
   logic        keep [4];

   always_comb begin
      keep[0] = 1'b1;
      keep[1] = ctl.four || ctl.nc_small == 2'd2;
      keep[2] = ctl.four;
      keep[3] = ctl.four;
      w[0] = '0;
      w[1] = '0;
      for (int i = 0; i < 4; i++) begin
         for (int b = 0; b < SW; b++) begin
            if ((i % 2) * 2 * SW + b < 64)
               w[i / 2][(i % 2) * 2 * SW + b] = keep[i] & ~ctl.zero & r_im[i][b];
            if ((i % 2) * 2 * SW + SW + b < 64)
               w[i / 2][(i % 2) * 2 * SW + SW + b] = keep[i] & ~ctl.zero & r_re[i][b];
         end
      end
      rsp.out_vis_lo = w[0];
      rsp.out_vis_hi = w[1];
      rsp.flag_out = ctl.flag | ctl.kerr;
      rsp.kind_error = ctl.kerr;
   end
endmodule
`default_nettype wire

// File: rtl/jva_checker.sv
`default_nettype none
module jva_sva (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire jva_pkg::rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");
   a_err_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind_error |-> rsp_data.flag_out)
      else $error("kind error without flag");
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.flag_out |->
         rsp_data.out_vis_lo == 64'd0 && rsp_data.out_vis_hi == 64'd0)
      else $error("flagged item carries data");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");
   a_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");
endmodule

bind jones_visibility_apply_core jva_sva u_jva_sva (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));
`default_nettype wire

// File: sim/jva_checker.sv
module jva_checker
   import jva_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire req_type                    req_data,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire rsp_type                    rsp_data,
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output int                              outstanding,
   output int                              mismatches
);

   logic [1:0] mode_q, rkind_q, lkind_q;
   rsp_type    pending_vis[$];

   assign outstanding = pending_vis.size();

   function automatic longint round_sat(longint acc);
      longint r;
      r = (acc + 64'sd4096) >>> 13;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   // a*b' + c*d', primes are conjugates when cj
   function automatic void mix(input longint ar, ai, br, bi, cr, ci, dr, di, input bit cj,
                               output longint rr, ri);
      longint sr, si;
      if (cj) begin
         sr = ar * br + ai * bi + cr * dr + ci * di;
         si = ai * br - ar * bi + ci * dr - cr * di;
      end else begin
         sr = ar * br - ai * bi + cr * dr - ci * di;
         si = ai * br + ar * bi + ci * dr + cr * di;
      end
      rr = round_sat(sr);
      ri = round_sat(si);
   endfunction

   function automatic logic [3:0] needed(logic [1:0] kind, int nc);
      if (kind == KIND_GENERAL) return 4'hF;
      if (kind == KIND_DIAGONAL && nc > 1) return 4'h3;
      return 4'h1;
   endfunction

   function automatic rsp_type corrected(req_type q);
      longint vr[4], vi[4], ar[4], ai[4], br[4], bi[4];
      longint jar[4], jai[4], jbr[4], jbi[4], tr[4], ti[4], rr[4], ri[4];
      longint xr, xi;
      logic [63:0] vw, aw, bw;
      logic [1:0] kr, kl;
      logic [3:0] nr, nl;
      int nc;
      bit flag, kerr;
      rsp_type o;
      nc = (mode_q == MODE_ONE) ? 1 : (mode_q == MODE_TWO) ? 2 : 4;
      kr = (rkind_q == 2'd3) ? KIND_SCALAR : rkind_q;
      kl = (lkind_q == 2'd3) ? KIND_SCALAR : lkind_q;
      for (int i = 0; i < 4; i++) begin
         vw = (i < 2) ? q.vis_lo : q.vis_hi;
         aw = (i < 2) ? q.right_gain_lo : q.right_gain_hi;
         bw = (i < 2) ? q.left_gain_lo : q.left_gain_hi;
         vi[i] = longint'($signed(vw[32*(i%2)    +:16]));
         vr[i] = longint'($signed(vw[32*(i%2)+16 +:16]));
         ai[i] = longint'($signed(aw[32*(i%2)    +:16]));
         ar[i] = longint'($signed(aw[32*(i%2)+16 +:16]));
         bi[i] = longint'($signed(bw[32*(i%2)    +:16]));
         br[i] = longint'($signed(bw[32*(i%2)+16 +:16]));
         rr[i] = 0;
         ri[i] = 0;
         jar[i] = 0; jai[i] = 0; jbr[i] = 0; jbi[i] = 0;
      end
      kerr = (nc < 4) && (kr == KIND_GENERAL || kl == KIND_GENERAL);
      nr = needed(kr, nc);
      nl = needed(kl, nc);
      flag = q.flag_in || ((q.right_valid & nr) != nr) || ((q.left_valid & nl) != nl);
      if (!flag && !kerr) begin
         if (kr == KIND_GENERAL) begin
            jar = ar; jai = ai;
         end else begin
            jar[0] = ar[0]; jai[0] = ai[0];
            jar[3] = (kr == KIND_DIAGONAL) ? ar[1] : ar[0];
            jai[3] = (kr == KIND_DIAGONAL) ? ai[1] : ai[0];
         end
         if (kl == KIND_GENERAL) begin
            jbr = br; jbi = bi;
         end else begin
            jbr[0] = br[0]; jbi[0] = bi[0];
            jbr[3] = (kl == KIND_DIAGONAL) ? br[1] : br[0];
            jbi[3] = (kl == KIND_DIAGONAL) ? bi[1] : bi[0];
         end
         if (nc == 4) begin
            for (int r = 0; r < 2; r++)
               for (int c = 0; c < 2; c++)
                  mix(jar[2*r], jai[2*r], vr[c], vi[c], jar[2*r+1], jai[2*r+1],
                      vr[2+c], vi[2+c], 1'b0, tr[2*r+c], ti[2*r+c]);
            for (int r = 0; r < 2; r++)
               for (int c = 0; c < 2; c++)
                  mix(tr[2*r], ti[2*r], jbr[2*c], jbi[2*c], tr[2*r+1], ti[2*r+1],
                      jbr[2*c+1], jbi[2*c+1], 1'b1, rr[2*r+c], ri[2*r+c]);
         end else begin
            for (int i = 0; i < nc; i++) begin
               mix(vr[i], vi[i], jar[3*i], jai[3*i], 0, 0, 0, 0, 1'b0, xr, xi);
               mix(xr, xi, jbr[3*i], jbi[3*i], 0, 0, 0, 0, 1'b1, rr[i], ri[i]);
            end
         end
      end
      o.out_vis_lo = {rr[1][15:0], ri[1][15:0], rr[0][15:0], ri[0][15:0]};
      o.out_vis_hi = {rr[3][15:0], ri[3][15:0], rr[2][15:0], ri[2][15:0]};
      o.flag_out = flag || kerr;
      o.kind_error = kerr;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mode_q <= MODE_FOUR;
         rkind_q <= KIND_GENERAL;
         lkind_q <= KIND_GENERAL;
         pending_vis.delete();
         mismatches <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_CORR_COUNT_MODE: mode_q <= csr_data;
               CSR_RIGHT_KIND: rkind_q <= csr_data;
               CSR_LEFT_KIND: lkind_q <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_vis.size() == 0) begin
               $error("unexpected item out");
               mismatches <= mismatches + 1;
            end else begin
               want = pending_vis.pop_front();
               if (want !== rsp_data) begin
                  if (want.out_vis_lo !== rsp_data.out_vis_lo)
                     $error("out_vis_lo exp %h got %h", want.out_vis_lo, rsp_data.out_vis_lo);
                  if (want.out_vis_hi !== rsp_data.out_vis_hi)
                     $error("out_vis_hi exp %h got %h", want.out_vis_hi, rsp_data.out_vis_hi);
                  if (want.flag_out !== rsp_data.flag_out)
                     $error("flag_out exp %b got %b", want.flag_out, rsp_data.flag_out);
                  if (want.kind_error !== rsp_data.kind_error)
                     $error("kind_error exp %b got %b", want.kind_error, rsp_data.kind_error);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_vis.push_back(corrected(req_data));
      end
   end

   final begin
      if (pending_vis.size() != 0)
         $error("%0d items never came out", pending_vis.size());
   end

endmodule

// File: sim/tb_top.sv
module tb_top;
   import jva_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;
   int outstanding, mismatches;
   int cycles = 0;

   always #10 clock = ~clock;

   jones_visibility_apply_core dut (.*);

   jva_checker chk (.*);

   // quiet window: no idling on either side
   function automatic bit calm();
      return (cycles % 5000) < 800;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_stall <= !calm() && ($urandom_range(0, 99) < 25);
      if (cycles > 400000) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send(req_type it);
      while (!calm() && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // mostly gains in -12000..12000 (below 1.5 in magnitude), sometimes anything
   function automatic logic [63:0] gain_word();
      logic [63:0] w;
      if ($urandom_range(0, 3) == 0) return rand_word();
      for (int k = 0; k < 4; k++)
         w[16*k +: 16] = 16'($signed($urandom_range(0, 24000)) - 12000);
      return w;
   endfunction

   function automatic req_type rand_item();
      req_type it;
      it.vis_lo = rand_word();
      it.vis_hi = rand_word();
      it.right_gain_lo = gain_word();
      it.right_gain_hi = gain_word();
      it.left_gain_lo = gain_word();
      it.left_gain_hi = gain_word();
      it.right_valid = 4'hF;
      it.left_valid = 4'hF;
      it.flag_in = 1'b0;
      if ($urandom_range(0, 99) < 15) begin
         it.right_valid = 4'($urandom);
         it.left_valid = 4'($urandom);
         it.flag_in = $urandom_range(0, 3) == 0;
      end
      return it;
   endfunction

   initial begin
      req_type it;
      logic [1:0] cfg[13][3] = '{
         '{MODE_FOUR, KIND_GENERAL, KIND_GENERAL}, '{MODE_ONE, KIND_DIAGONAL, KIND_SCALAR},
         '{MODE_TWO, KIND_DIAGONAL, KIND_DIAGONAL}, '{MODE_ONE, KIND_SCALAR, KIND_DIAGONAL},
         '{MODE_TWO, KIND_SCALAR, KIND_SCALAR}, '{2'd3, KIND_GENERAL, KIND_DIAGONAL},
         '{MODE_FOUR, 2'd3, 2'd3}, '{MODE_ONE, KIND_GENERAL, KIND_DIAGONAL},
         '{MODE_TWO, KIND_SCALAR, KIND_GENERAL}, '{MODE_FOUR, KIND_DIAGONAL, KIND_SCALAR},
         '{2'd3, KIND_DIAGONAL, KIND_GENERAL}, '{MODE_ONE, 2'd3, 2'd3},
         '{MODE_FOUR, KIND_GENERAL, KIND_GENERAL}};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items at reset settings
      it = '0;
      it.right_valid = 4'hF;
      it.left_valid = 4'hF;
      send(it);
      it.vis_lo = {4{16'h7FFF}}; it.vis_hi = {4{16'h7FFF}};
      it.right_gain_lo = {4{16'h7FFF}}; it.right_gain_hi = {4{16'h7FFF}};
      it.left_gain_lo = {4{16'h7FFF}}; it.left_gain_hi = {4{16'h7FFF}};
      send(it);
      it.vis_lo = {4{16'h8000}}; it.vis_hi = {4{16'h8000}};
      it.right_gain_lo = {4{16'h8000}}; it.right_gain_hi = {4{16'h8000}};
      it.left_gain_lo = {4{16'h8000}}; it.left_gain_hi = {4{16'h8000}};
      send(it);
      it.vis_lo = rand_word(); it.vis_hi = rand_word();
      it.right_gain_lo = {16'h2000, 16'h0, 16'h0, 16'h0};
      it.right_gain_hi = {16'h0, 16'h0, 16'h2000, 16'h0};
      it.left_gain_lo = it.right_gain_lo; it.left_gain_hi = it.right_gain_hi;
      send(it);
      it.flag_in = 1'b1;
      send(it);
      it.flag_in = 1'b0;
      for (int b = 0; b < 4; b++) begin
         it.right_valid = 4'hF ^ (4'h1 << b);
         send(it);
         it.right_valid = 4'hF;
         it.left_valid = 4'hF ^ (4'h1 << b);
         send(it);
         it.left_valid = 4'hF;
      end

      for (int p = 0; p < 13; p++) begin
         req_valid <= 1'b0;
         drain();
         write_reg(CSR_CORR_COUNT_MODE, cfg[p][0]);
         write_reg(CSR_RIGHT_KIND, cfg[p][1]);
         write_reg(CSR_LEFT_KIND, cfg[p][2]);
         for (int n = 0; n < 148; n++) send(rand_item());
      end
      req_valid <= 1'b0;
      drain();

      if (mismatches == 0 && outstanding == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
